// ===== hw/rtl/alu8_pkg.sv =====
// package: operation codes and request/response types of the 8-bit alu
`default_nettype none

package alu8_pkg;

  // flag bit positions in the 4-bit flag field
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  // decimal adjust constants
  localparam logic [7:0] DaaLimit  = 8'h99;
  localparam logic [7:0] DaaHiCorr = 8'h60;
  localparam logic [7:0] DaaLoCorr = 8'h06;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_ADC    = 5'd1,
    OP_SUB    = 5'd2,
    OP_SBC    = 5'd3,
    OP_AND    = 5'd4,
    OP_XOR    = 5'd5,
    OP_OR     = 5'd6,
    OP_CP     = 5'd7,
    OP_INC    = 5'd8,
    OP_DEC    = 5'd9,
    OP_ADD16  = 5'd10,
    OP_ADDSP  = 5'd11,
    OP_DAA    = 5'd12,
    OP_CPL    = 5'd13,
    OP_SCF    = 5'd14,
    OP_CCF    = 5'd15,
    OP_RLCA   = 5'd16,
    OP_RRCA   = 5'd17,
    OP_RLA    = 5'd18,
    OP_RRA    = 5'd19,
    OP_RLC    = 5'd20,
    OP_RRC    = 5'd21,
    OP_RL     = 5'd22,
    OP_RR     = 5'd23,
    OP_SLA    = 5'd24,
    OP_SRA    = 5'd25,
    OP_SWAP   = 5'd26,
    OP_SRL    = 5'd27,
    OP_BIT    = 5'd28,
    OP_RES    = 5'd29,
    OP_SET    = 5'd30,
    OP_LDHLSP = 5'd31
  } alu8_op_e;

  typedef struct packed {
    alu8_op_e    operation;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } alu8_req_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic        write_result;
  } alu8_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/eight_bit_cpu_alu_with_flags.sv =====
// top level of the 8-bit cpu alu: request register, datapath, response register
`default_nettype none

// usage
//   request side: drive req_i and raise start_i; a request is taken at every
//   rising edge where start_i is high and busy_o is low. busy_o stays low, so
//   a new request can be issued in every cycle.
//   response side: after the request and response registers, done_o is high for
//   exactly one cycle and rsp_o carries result, flags_out and write_result.
//   the receiver cannot stall; it must capture rsp_o in the done_o cycle.
//   pipeline: request register, then response register
//   throughput: 1 request per cycle, set by the single-pass datapath between
//   the two registers (8-bit and 16-bit adders plus result and flag muxing)
//   reset: rst_ni low clears both valid bits, so no response is pending and
//   done_o reads low; the request and response payload registers are not reset
//   operations that leave flags alone (res, set) copy flags_in to flags_out

module eight_bit_cpu_alu_with_flags (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  alu8_pkg::alu8_req_t req_i,
  output logic                done_o,
  output alu8_pkg::alu8_rsp_t rsp_o
);

  logic                req_vld_q, req_vld_d;
  alu8_pkg::alu8_req_t req_q;
  alu8_pkg::alu8_rsp_t rsp_d, rsp_q;
  logic                done_q;
  logic                accept;

  // never busy: every stage advances each cycle
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign req_vld_d = accept;

  // request register, payload needs no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= req_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // combinational alu between the two registers
  alu8_core u_core (
    .req_i (req_q),
    .rsp_o (rsp_d)
  );

  // response register with one-cycle done strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/alu8_core.sv =====
// combinational datapath of the 8-bit alu with flag generation
`default_nettype none

module alu8_core (
  input  alu8_pkg::alu8_req_t req_i,
  output alu8_pkg::alu8_rsp_t rsp_o
);

  logic [7:0]  a8, b8;
  logic        zi, ni, hi, ci;
  logic        cin_add, cin_sub;
  logic [8:0]  sum9;
  logic [4:0]  sum_lo;
  logic [8:0]  dif9;
  logic [4:0]  dif_lo;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] sp_sum;
  logic [7:0]  daa_v;
  logic        daa_c;
  logic [7:0]  r8;
  logic [15:0] r16;
  logic        wide;
  logic [3:0]  f;
  logic        zsel;
  logic        wr;
  logic [7:0]  bit_mask;

  assign a8 = req_i.operand_a[7:0];
  assign b8 = req_i.operand_b[7:0];
  assign zi = req_i.flags_in[alu8_pkg::FlagZ];
  assign ni = req_i.flags_in[alu8_pkg::FlagN];
  assign hi = req_i.flags_in[alu8_pkg::FlagH];
  assign ci = req_i.flags_in[alu8_pkg::FlagC];

  assign cin_add = (req_i.operation == alu8_pkg::OP_ADC) ? ci : 1'b0;
  assign cin_sub = (req_i.operation == alu8_pkg::OP_SBC) ? ci : 1'b0;

  // shared 8-bit adder, also gives the low-byte carries of the sp ops
  assign sum9   = {1'b0, a8} + {1'b0, b8} + {8'd0, cin_add};
  assign sum_lo = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin_add};
  assign dif9   = {1'b0, a8} - {1'b0, b8} - {8'd0, cin_sub};
  assign dif_lo = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin_sub};

  assign sum17  = {1'b0, req_i.operand_a} + {1'b0, req_i.operand_b};
  assign sum13  = {1'b0, req_i.operand_a[11:0]} + {1'b0, req_i.operand_b[11:0]};
  assign sp_sum = req_i.operand_a + {{8{b8[7]}}, b8};

  assign bit_mask = 8'd1 << req_i.bit_index;

  // decimal adjust
  always_comb begin
    daa_v = a8;
    daa_c = ci;
    if (!ni) begin
      if (ci || (a8 > alu8_pkg::DaaLimit)) begin
        daa_v = daa_v + alu8_pkg::DaaHiCorr;
        daa_c = 1'b1;
      end
      if (hi || (a8[3:0] > 4'd9)) begin
        daa_v = daa_v + alu8_pkg::DaaLoCorr;
      end
    end else begin
      if (ci) begin
        daa_v = daa_v - alu8_pkg::DaaHiCorr;
      end
      if (hi) begin
        daa_v = daa_v - alu8_pkg::DaaLoCorr;
      end
    end
  end

  // result select; zsel marks ops whose z flag is taken from the 8-bit result
  always_comb begin
    r8   = a8;
    r16  = 16'd0;
    wide = 1'b0;
    f    = req_i.flags_in;
    zsel = 1'b0;
    wr   = 1'b1;
    unique case (req_i.operation)
      alu8_pkg::OP_ADD, alu8_pkg::OP_ADC: begin
        r8   = sum9[7:0];
        zsel = 1'b1;
        f    = {1'b0, 1'b0, sum_lo[4], sum9[8]};
      end
      alu8_pkg::OP_SUB, alu8_pkg::OP_SBC: begin
        r8   = dif9[7:0];
        zsel = 1'b1;
        f    = {1'b0, 1'b1, dif_lo[4], dif9[8]};
      end
      alu8_pkg::OP_CP: begin
        r8   = dif9[7:0];
        zsel = 1'b1;
        wr   = 1'b0;
        f    = {1'b0, 1'b1, dif_lo[4], dif9[8]};
      end
      alu8_pkg::OP_AND: begin
        r8   = a8 & b8;
        zsel = 1'b1;
        f    = 4'b0010;
      end
      alu8_pkg::OP_XOR: begin
        r8   = a8 ^ b8;
        zsel = 1'b1;
        f    = 4'b0000;
      end
      alu8_pkg::OP_OR: begin
        r8   = a8 | b8;
        zsel = 1'b1;
        f    = 4'b0000;
      end
      alu8_pkg::OP_INC: begin
        r8   = a8 + 8'd1;
        zsel = 1'b1;
        f    = {1'b0, 1'b0, (a8[3:0] == 4'hF), ci};
      end
      alu8_pkg::OP_DEC: begin
        r8   = a8 - 8'd1;
        zsel = 1'b1;
        f    = {1'b0, 1'b1, (a8[3:0] == 4'h0), ci};
      end
      alu8_pkg::OP_ADD16: begin
        wide = 1'b1;
        r16  = sum17[15:0];
        f    = {zi, 1'b0, sum13[12], sum17[16]};
      end
      alu8_pkg::OP_ADDSP, alu8_pkg::OP_LDHLSP: begin
        wide = 1'b1;
        r16  = sp_sum;
        f    = {1'b0, 1'b0, sum_lo[4], sum9[8]};
      end
      alu8_pkg::OP_DAA: begin
        r8   = daa_v;
        zsel = 1'b1;
        f    = {1'b0, ni, 1'b0, daa_c};
      end
      alu8_pkg::OP_CPL: begin
        r8 = ~a8;
        f  = {zi, 1'b1, 1'b1, ci};
      end
      alu8_pkg::OP_SCF: begin
        wr = 1'b0;
        f  = {zi, 1'b0, 1'b0, 1'b1};
      end
      alu8_pkg::OP_CCF: begin
        wr = 1'b0;
        f  = {zi, 1'b0, 1'b0, ~ci};
      end
      alu8_pkg::OP_RLCA: begin
        r8 = {a8[6:0], a8[7]};
        f  = {1'b0, 1'b0, 1'b0, a8[7]};
      end
      alu8_pkg::OP_RRCA: begin
        r8 = {a8[0], a8[7:1]};
        f  = {1'b0, 1'b0, 1'b0, a8[0]};
      end
      alu8_pkg::OP_RLA: begin
        r8 = {a8[6:0], ci};
        f  = {1'b0, 1'b0, 1'b0, a8[7]};
      end
      alu8_pkg::OP_RRA: begin
        r8 = {ci, a8[7:1]};
        f  = {1'b0, 1'b0, 1'b0, a8[0]};
      end
      alu8_pkg::OP_RLC: begin
        r8   = {a8[6:0], a8[7]};
        zsel = 1'b1;
        f    = {1'b0, 1'b0, 1'b0, a8[7]};
      end
      alu8_pkg::OP_RRC: begin
        r8   = {a8[0], a8[7:1]};
        zsel = 1'b1;
        f    = {1'b0, 1'b0, 1'b0, a8[0]};
      end
      alu8_pkg::OP_RL: begin
        r8   = {a8[6:0], ci};
        zsel = 1'b1;
        f    = {1'b0, 1'b0, 1'b0, a8[7]};
      end
      alu8_pkg::OP_RR: begin
        r8   = {ci, a8[7:1]};
        zsel = 1'b1;
        f    = {1'b0, 1'b0, 1'b0, a8[0]};
      end
      alu8_pkg::OP_SLA: begin
        r8   = {a8[6:0], 1'b0};
        zsel = 1'b1;
        f    = {1'b0, 1'b0, 1'b0, a8[7]};
      end
      alu8_pkg::OP_SRA: begin
        r8   = {a8[7], a8[7:1]};
        zsel = 1'b1;
        f    = {1'b0, 1'b0, 1'b0, a8[0]};
      end
      alu8_pkg::OP_SWAP: begin
        r8   = {a8[3:0], a8[7:4]};
        zsel = 1'b1;
        f    = 4'b0000;
      end
      alu8_pkg::OP_SRL: begin
        r8   = {1'b0, a8[7:1]};
        zsel = 1'b1;
        f    = {1'b0, 1'b0, 1'b0, a8[0]};
      end
      alu8_pkg::OP_BIT: begin
        wr = 1'b0;
        f  = {~a8[req_i.bit_index], 1'b0, 1'b1, ci};
      end
      alu8_pkg::OP_RES: begin
        r8 = a8 & ~bit_mask;
      end
      alu8_pkg::OP_SET: begin
        r8 = a8 | bit_mask;
      end
      default: begin
        r8 = a8;
      end
    endcase
  end

  always_comb begin
    rsp_o.result       = wide ? r16 : {8'd0, r8};
    rsp_o.flags_out    = f;
    rsp_o.write_result = wr;
    if (zsel) begin
      rsp_o.flags_out[alu8_pkg::FlagZ] = (r8 == 8'd0);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/alu8_checker.sv =====
// port-level checker for the 8-bit alu and its bind to the top level
`default_nettype none

module alu8_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input alu8_pkg::alu8_req_t req_i,
  input logic                done_o,
  input alu8_pkg::alu8_rsp_t rsp_o
);

  logic acc;
  assign acc = start_i & ~busy_o;

  // every taken request yields a response after the request and response registers
  a_req_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##2 done_o)
    else $error("request not answered after two cycles");

  // no response without an earlier taken request
  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, 2))
    else $error("response without request");

  // compare never writes the destination
  a_cp_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(req_i.operation, 2) == alu8_pkg::OP_CP) |->
      !rsp_o.write_result)
    else $error("compare wrote destination");

  // res and set leave the flags unchanged
  a_bitop_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(req_i.operation, 2) == alu8_pkg::OP_RES ||
                $past(req_i.operation, 2) == alu8_pkg::OP_SET)) |->
      rsp_o.flags_out == $past(req_i.flags_in, 2))
    else $error("res/set changed flags");

endmodule

bind eight_bit_cpu_alu_with_flags alu8_checker u_alu8_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);

`default_nettype wire

// ===== bench/tb.sv =====
// testbench: directed and random requests, checked by a flag-exact predictor or pinned responses
`timescale 1ns / 1ps

module tb;
  import alu8_pkg::*;

  localparam int unsigned RandomCount = 1100;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 4;

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      start_i = 1'b0;
  alu8_req_t req_i   = '0;
  logic      busy_o;
  logic      done_o;
  alu8_rsp_t rsp_o;

  eight_bit_cpu_alu_with_flags i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // one row of the directed table; pinned rows carry a hand-written response
  typedef struct {
    alu8_req_t req;
    bit        pinned;
    alu8_rsp_t rsp;
  } vector_t;

  vector_t     directed_q[$];
  alu8_rsp_t   pending_rsp_q[$];
  alu8_rsp_t   want_rsp;
  int unsigned mismatch_count = 0;
  int unsigned issued_count   = 0;
  int unsigned cycle_count    = 0;

  // expected response of one request
  function automatic alu8_rsp_t alu_expect(alu8_req_t q);
    alu8_rsp_t   p;
    logic [7:0]  a8, b8, r8, dv;
    logic [8:0]  s9;
    logic [4:0]  h5;
    logic [12:0] s13;
    logic [16:0] s17;
    logic [15:0] offset;
    logic        z, n, h, c, ci, cy, wide;
    a8   = q.operand_a[7:0];
    b8   = q.operand_b[7:0];
    ci   = q.flags_in[FlagC];
    z    = q.flags_in[FlagZ];
    n    = q.flags_in[FlagN];
    h    = q.flags_in[FlagH];
    c    = ci;
    r8   = 8'h00;
    wide = 1'b0;
    p.result       = '0;
    p.write_result = 1'b1;
    case (q.operation)
      OP_ADD, OP_ADC: begin
        cy = (q.operation == OP_ADC) ? ci : 1'b0;
        s9 = {1'b0, a8} + {1'b0, b8} + {8'h00, cy};
        h5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'h0, cy};
        r8 = s9[7:0];
        z = (r8 == 8'h00); n = 1'b0; h = h5[4]; c = s9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        cy = (q.operation == OP_SBC) ? ci : 1'b0;
        r8 = a8 - b8 - {7'h00, cy};
        z = (r8 == 8'h00);
        n = 1'b1;
        h = {1'b0, a8[3:0]} < ({1'b0, b8[3:0]} + {4'h0, cy});
        c = {1'b0, a8} < ({1'b0, b8} + {8'h00, cy});
        if (q.operation == OP_CP) p.write_result = 1'b0;
      end
      OP_AND: begin
        r8 = a8 & b8;
        z = (r8 == 8'h00); n = 1'b0; h = 1'b1; c = 1'b0;
      end
      OP_XOR, OP_OR: begin
        r8 = (q.operation == OP_XOR) ? (a8 ^ b8) : (a8 | b8);
        z = (r8 == 8'h00); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      OP_INC: begin
        r8 = a8 + 8'h01;
        z = (r8 == 8'h00); n = 1'b0; h = (a8[3:0] == 4'hF);
      end
      OP_DEC: begin
        r8 = a8 - 8'h01;
        z = (r8 == 8'h00); n = 1'b1; h = (a8[3:0] == 4'h0);
      end
      OP_ADD16: begin
        wide = 1'b1;
        s17 = {1'b0, q.operand_a} + {1'b0, q.operand_b};
        s13 = {1'b0, q.operand_a[11:0]} + {1'b0, q.operand_b[11:0]};
        p.result = s17[15:0];
        n = 1'b0; h = s13[12]; c = s17[16];
      end
      OP_ADDSP, OP_LDHLSP: begin
        // signed offset from the low byte; carries come from the unsigned low-byte add
        wide = 1'b1;
        offset = {{8{b8[7]}}, b8};
        p.result = q.operand_a + offset;
        h5 = {1'b0, q.operand_a[3:0]} + {1'b0, b8[3:0]};
        s9 = {1'b0, q.operand_a[7:0]} + {1'b0, b8};
        z = 1'b0; n = 1'b0; h = h5[4]; c = s9[8];
      end
      OP_DAA: begin
        dv = a8;
        if (!q.flags_in[FlagN]) begin
          if (ci || a8 > DaaLimit) begin
            dv = dv + DaaHiCorr;
            c = 1'b1;
          end
          if (q.flags_in[FlagH] || a8[3:0] > 4'd9) dv = dv + DaaLoCorr;
        end else begin
          if (ci) dv = dv - DaaHiCorr;
          if (q.flags_in[FlagH]) dv = dv - DaaLoCorr;
        end
        r8 = dv;
        z = (r8 == 8'h00); h = 1'b0;
      end
      OP_CPL: begin
        r8 = ~a8;
        n = 1'b1; h = 1'b1;
      end
      OP_SCF, OP_CCF: begin
        r8 = a8;
        p.write_result = 1'b0;
        n = 1'b0; h = 1'b0;
        c = (q.operation == OP_SCF) ? 1'b1 : ~ci;
      end
      OP_RLCA, OP_RLC: begin
        r8 = {a8[6:0], a8[7]};
        z = (q.operation == OP_RLC) && (r8 == 8'h00); n = 1'b0; h = 1'b0; c = a8[7];
      end
      OP_RRCA, OP_RRC: begin
        r8 = {a8[0], a8[7:1]};
        z = (q.operation == OP_RRC) && (r8 == 8'h00); n = 1'b0; h = 1'b0; c = a8[0];
      end
      OP_RLA, OP_RL: begin
        r8 = {a8[6:0], ci};
        z = (q.operation == OP_RL) && (r8 == 8'h00); n = 1'b0; h = 1'b0; c = a8[7];
      end
      OP_RRA, OP_RR: begin
        r8 = {ci, a8[7:1]};
        z = (q.operation == OP_RR) && (r8 == 8'h00); n = 1'b0; h = 1'b0; c = a8[0];
      end
      OP_SLA: begin
        r8 = {a8[6:0], 1'b0};
        z = (r8 == 8'h00); n = 1'b0; h = 1'b0; c = a8[7];
      end
      OP_SRA: begin
        r8 = {a8[7], a8[7:1]};
        z = (r8 == 8'h00); n = 1'b0; h = 1'b0; c = a8[0];
      end
      OP_SWAP: begin
        r8 = {a8[3:0], a8[7:4]};
        z = (r8 == 8'h00); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      OP_SRL: begin
        r8 = {1'b0, a8[7:1]};
        z = (r8 == 8'h00); n = 1'b0; h = 1'b0; c = a8[0];
      end
      OP_BIT: begin
        r8 = a8;
        p.write_result = 1'b0;
        z = ~a8[q.bit_index]; n = 1'b0; h = 1'b1;
      end
      OP_RES: r8 = a8 & ~(8'h01 << q.bit_index);
      OP_SET: r8 = a8 | (8'h01 << q.bit_index);
      default: r8 = a8;
    endcase
    if (!wide) p.result = {8'h00, r8};
    p.flags_out[FlagZ] = z;
    p.flags_out[FlagN] = n;
    p.flags_out[FlagH] = h;
    p.flags_out[FlagC] = c;
    return p;
  endfunction

  task automatic add_vector(input alu8_op_e op, input logic [15:0] a, input logic [15:0] b,
                            input logic [2:0] idx, input logic [3:0] fl, input bit pinned,
                            input logic [15:0] res, input logic [3:0] flo, input logic wr);
    vector_t v;
    v.req.operation       = op;
    v.req.operand_a       = a;
    v.req.operand_b       = b;
    v.req.bit_index       = idx;
    v.req.flags_in        = fl;
    v.pinned              = pinned;
    v.rsp.result          = res;
    v.rsp.flags_out       = flo;
    v.rsp.write_result    = wr;
    directed_q.push_back(v);
  endtask

  // mostly short gaps, a few long ones, and every third stretch back to back
  function automatic int unsigned pick_gap(int unsigned n);
    int unsigned roll;
    roll = $urandom_range(99);
    if ((n / 128) % 3 == 2) return 0;
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // operand with a bias toward carry and borrow boundaries
  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(7))
      0: w = 16'h0000;
      1: w = 16'hFFFF;
      2: w[7:0] = 8'hFF;
      3: w[3:0] = 4'hF;
      4: w[3:0] = 4'h0;
      5: w[11:0] = 12'hFFF;
      default: ;
    endcase
    return w;
  endfunction

  task automatic issue_request(input alu8_req_t r, input bit pinned, input alu8_rsp_t fixed);
    int unsigned gap;
    gap = pick_gap(issued_count);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    // taken at the first edge that sees busy low
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_rsp_q.push_back(pinned ? fixed : alu_expect(r));
    issued_count++;
  endtask

  // response checker, in order, one strobe per response
  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) begin
      if (pending_rsp_q.size() == 0) begin
        $error("unexpected response: result %h flags %h", rsp_o.result, rsp_o.flags_out);
        mismatch_count++;
      end else begin
        want_rsp = pending_rsp_q.pop_front();
        if (rsp_o.result !== want_rsp.result) begin
          $error("result: expected %h, got %h", want_rsp.result, rsp_o.result);
          mismatch_count++;
        end
        if (rsp_o.flags_out !== want_rsp.flags_out) begin
          $error("flags_out: expected %h, got %h", want_rsp.flags_out, rsp_o.flags_out);
          mismatch_count++;
        end
        if (rsp_o.write_result !== want_rsp.write_result) begin
          $error("write_result: expected %b, got %b", want_rsp.write_result,
                 rsp_o.write_result);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    alu8_req_t r;
    alu8_rsp_t none;
    none = '0;

    // operand extremes, carry and borrow boundaries, high bytes that must be ignored
    add_vector(OP_ADD,    16'hABFF, 16'hCD01, 3'd0, 4'h0, 1'b1, 16'h0000, 4'hB, 1'b1);
    add_vector(OP_ADC,    16'h000F, 16'h0000, 3'd0, 4'h1, 1'b1, 16'h0010, 4'h2, 1'b1);
    add_vector(OP_SUB,    16'h0000, 16'h0001, 3'd0, 4'h0, 1'b1, 16'h00FF, 4'h7, 1'b1);
    add_vector(OP_SBC,    16'h0010, 16'h000F, 3'd0, 4'h1, 1'b1, 16'h0000, 4'hE, 1'b1);
    add_vector(OP_AND,    16'h00F0, 16'h000F, 3'd0, 4'hF, 1'b1, 16'h0000, 4'hA, 1'b1);
    add_vector(OP_XOR,    16'hFFFF, 16'hFFFF, 3'd0, 4'h7, 1'b1, 16'h0000, 4'h8, 1'b1);
    add_vector(OP_OR,     16'h0080, 16'h0001, 3'd0, 4'hF, 1'b1, 16'h0081, 4'h0, 1'b1);
    add_vector(OP_CP,     16'h0042, 16'h0042, 3'd0, 4'h0, 1'b1, 16'h0000, 4'hC, 1'b0);
    add_vector(OP_INC,    16'h00FF, 16'h0000, 3'd0, 4'h1, 1'b1, 16'h0000, 4'hB, 1'b1);
    add_vector(OP_DEC,    16'h0000, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h00FF, 4'h6, 1'b1);
    // 16-bit add keeps Z; sp offset add clears it
    add_vector(OP_ADD16,  16'hFFFF, 16'h0001, 3'd0, 4'h8, 1'b1, 16'h0000, 4'hB, 1'b1);
    add_vector(OP_ADDSP,  16'h0000, 16'h00FF, 3'd0, 4'hF, 1'b1, 16'hFFFF, 4'h0, 1'b1);
    add_vector(OP_LDHLSP, 16'h00FF, 16'hFF01, 3'd0, 4'h0, 1'b1, 16'h0100, 4'h3, 1'b1);
    // decimal adjust after add with both corrections, and after subtract
    add_vector(OP_DAA,    16'h009A, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'h9, 1'b1);
    add_vector(OP_DAA,    16'h0000, 16'h0000, 3'd0, 4'h7, 1'b0, 16'h0000, 4'h0, 1'b0);
    add_vector(OP_CPL,    16'h005A, 16'h0000, 3'd0, 4'h9, 1'b1, 16'h00A5, 4'hF, 1'b1);
    add_vector(OP_SCF,    16'h1234, 16'h0000, 3'd0, 4'hE, 1'b1, 16'h0034, 4'h9, 1'b0);
    add_vector(OP_CCF,    16'h0077, 16'h0000, 3'd0, 4'h1, 1'b1, 16'h0077, 4'h0, 1'b0);
    // accumulator rotates never set Z, prefixed ones do
    add_vector(OP_RLCA,   16'h0080, 16'h0000, 3'd0, 4'h8, 1'b1, 16'h0001, 4'h1, 1'b1);
    add_vector(OP_RRCA,   16'h0001, 16'h0000, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0);
    add_vector(OP_RLA,    16'h0080, 16'h0000, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0);
    add_vector(OP_RRA,    16'h0001, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'h1, 1'b1);
    add_vector(OP_RLC,    16'h0000, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'h8, 1'b1);
    add_vector(OP_RRC,    16'h0001, 16'h0000, 3'd0, 4'hF, 1'b0, 16'h0000, 4'h0, 1'b0);
    add_vector(OP_RL,     16'h0080, 16'h0000, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0);
    add_vector(OP_RR,     16'h0001, 16'h0000, 3'd0, 4'h1, 1'b1, 16'h0080, 4'h1, 1'b1);
    add_vector(OP_SLA,    16'h0080, 16'h0000, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0);
    // arithmetic shift keeps the sign bit
    add_vector(OP_SRA,    16'h0081, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h00C0, 4'h1, 1'b1);
    add_vector(OP_SWAP,   16'h00F0, 16'h0000, 3'd0, 4'hF, 1'b1, 16'h000F, 4'h0, 1'b1);
    add_vector(OP_SRL,    16'h0001, 16'h0000, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0);
    add_vector(OP_BIT,    16'h007F, 16'h0000, 3'd7, 4'h1, 1'b1, 16'h007F, 4'hB, 1'b0);
    add_vector(OP_RES,    16'h00FF, 16'h0000, 3'd7, 4'h5, 1'b1, 16'h007F, 4'h5, 1'b1);
    add_vector(OP_SET,    16'h0000, 16'h0000, 3'd0, 4'hA, 1'b1, 16'h0001, 4'hA, 1'b1);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) begin
      issue_request(directed_q[i].req, directed_q[i].pinned, directed_q[i].rsp);
    end

    for (int unsigned k = 0; k < RandomCount; k++) begin
      r.operation = alu8_op_e'($urandom_range(31));
      r.operand_a = pick_word();
      r.operand_b = pick_word();
      r.bit_index = 3'($urandom_range(7));
      r.flags_in  = 4'($urandom_range(15));
      issue_request(r, 1'b0, none);
    end
    start_i <= 1'b0;

    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/alu8_pkg.sv
hw/rtl/alu8_core.sv
hw/rtl/eight_bit_cpu_alu_with_flags.sv
hw/rtl/alu8_checker.sv
bench/tb.sv
